// ----- hdl/sidq_pkg.sv -----
package sidq_pkg;

    localparam int SIDQ_CAPACITY = 16;
    localparam int DATA_W        = 32;
    localparam int COUNT_OUT_W   = 5;

    typedef enum logic [2:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_DELETE     = 3'd4,
        CMD_INSERT     = 3'd5
    } cmd_t;

    // Where the forward pass starts
    typedef enum logic [1:0] {
        START_FRONT,
        START_LAST,
        START_END
    } start_t;

    // Which entry the pass stops on (removes, or opens a gap before)
    typedef enum logic [1:0] {
        MATCH_ALWAYS,
        MATCH_EQ,
        MATCH_GT
    } match_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic   load;
        logic   mode_insert;
        match_t match_kind;
        start_t start_sel;
        logic   skip;
        logic   reject;
        logic   read_en;
        logic   finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic full;
        logic scan_done;
        logic pend_valid;
        logic out_free;
    } dp_status_t;

endpackage

// ----- hdl/sidq_ram.sv -----
module sidq_ram #(
    parameter int WIDTH = sidq_pkg::DATA_W,
    parameter int DEPTH = sidq_pkg::SIDQ_CAPACITY
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/sidq_ctrl.sv -----
module sidq_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [2:0]             cmd,
    input  sidq_pkg::dp_status_t   st,
    output sidq_pkg::ctrl_cmd_t    ctl
);
    import sidq_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        ctl             = '0;
        ctl.match_kind  = MATCH_ALWAYS;
        ctl.start_sel   = START_FRONT;
        in_stall        = 1'b1;

        // decode the command beat; used only with load
        unique case (cmd)
            CMD_PUSH_FRONT:
            begin
                ctl.mode_insert = 1'b1;
                ctl.reject      = st.full;
            end
            CMD_PUSH_BACK:
            begin
                ctl.mode_insert = 1'b1;
                ctl.start_sel   = START_END;
                ctl.reject      = st.full;
            end
            CMD_POP_FRONT:
            begin
                ctl.mode_insert = 1'b0;
            end
            CMD_POP_BACK:
            begin
                ctl.start_sel = START_LAST;
            end
            CMD_DELETE:
            begin
                ctl.match_kind = MATCH_EQ;
            end
            CMD_INSERT:
            begin
                ctl.mode_insert = 1'b1;
                ctl.match_kind  = MATCH_GT;
                ctl.reject      = st.full;
            end
            default:
            begin
                ctl.skip = 1'b1;
            end
        endcase
        if (ctl.reject)
        begin
            ctl.skip = 1'b1;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    ctl.load   = 1'b1;
                    state_next = ctl.skip ? ST_FINISH : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                ctl.read_en = !st.scan_done;
                if (st.scan_done && !st.pend_valid)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                // hold until the output register can take the result
                if (st.out_free)
                begin
                    ctl.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_finish_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.finish |-> !st.pend_valid)
        else $error("finish issued with a read still in flight");

    a_no_read_past_end: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.read_en |-> !st.scan_done)
        else $error("read issued past the last entry");

    a_finish_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.finish |-> st.out_free)
        else $error("finish issued while the output register is occupied");

endmodule

// ----- hdl/sidq_dpath.sv -----
module sidq_dpath #(
    parameter int CAPACITY = sidq_pkg::SIDQ_CAPACITY
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  sidq_pkg::ctrl_cmd_t                    ctl,
    output sidq_pkg::dp_status_t                   st,
    input  logic signed [sidq_pkg::DATA_W-1:0]     data_value,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [sidq_pkg::DATA_W-1:0]     result_value,
    output logic                                   found,
    output logic                                   full_error,
    output logic [sidq_pkg::COUNT_OUT_W-1:0]       entry_count
);
    import sidq_pkg::*;

    localparam int AW    = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    logic [CNT_W-1:0]         count_reg, count_next;
    logic [CNT_W-1:0]         rd_idx_reg, rd_idx_next;
    logic                     pend_valid_reg, pend_valid_next;
    logic [AW-1:0]            pend_idx_reg, pend_idx_next;
    logic                     act_reg, act_next;
    logic [DATA_W-1:0]        hold_reg, hold_next;
    logic signed [DATA_W-1:0] value_reg;
    logic                     mode_insert_reg;
    match_t                   match_reg;
    logic                     skip_reg;
    logic                     reject_reg;

    logic                     out_valid_reg;
    logic signed [DATA_W-1:0] result_value_reg;
    logic                     found_reg;
    logic                     full_error_reg;
    logic [COUNT_OUT_W-1:0]   entry_count_reg;

    logic                     ram_we;
    logic [AW-1:0]            ram_waddr;
    logic [DATA_W-1:0]        ram_wdata;
    logic [DATA_W-1:0]        ram_rdata;
    logic                     hit;

    sidq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ctl.read_en),
        .raddr (rd_idx_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        case (match_reg)
            MATCH_EQ: hit = (ram_rdata == value_reg);
            MATCH_GT: hit = ($signed(ram_rdata) > value_reg);
            default:  hit = 1'b1;
        endcase
    end

    always_comb
    begin
        ram_we          = 1'b0;
        ram_waddr       = pend_idx_reg;
        ram_wdata       = ram_rdata;
        act_next        = act_reg;
        hold_next       = hold_reg;
        count_next      = count_reg;
        rd_idx_next     = rd_idx_reg;
        pend_valid_next = 1'b0;
        pend_idx_next   = pend_idx_reg;

        if (ctl.read_en)
        begin
            rd_idx_next     = rd_idx_reg + CNT_W'(1);
            pend_valid_next = 1'b1;
            pend_idx_next   = rd_idx_reg[AW-1:0];
        end

        if (pend_valid_reg)
        begin
            if (mode_insert_reg)
            begin
                // ripple the displaced entry one place toward the back
                if (act_reg)
                begin
                    ram_we    = 1'b1;
                    ram_wdata = hold_reg;
                    hold_next = ram_rdata;
                end
                else if (hit)
                begin
                    ram_we    = 1'b1;
                    ram_wdata = value_reg;
                    hold_next = ram_rdata;
                    act_next  = 1'b1;
                end
            end
            else
            begin
                // close the gap behind the removed entry
                if (act_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = pend_idx_reg - AW'(1);
                end
                else if (hit)
                begin
                    hold_next = ram_rdata;
                    act_next  = 1'b1;
                end
            end
        end

        if (ctl.finish && !skip_reg)
        begin
            if (mode_insert_reg)
            begin
                ram_we     = 1'b1;
                ram_waddr  = count_reg[AW-1:0];
                ram_wdata  = act_reg ? hold_reg : value_reg;
                count_next = count_reg + CNT_W'(1);
            end
            else if (act_reg)
            begin
                count_next = count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            rd_idx_reg     <= '0;
            pend_valid_reg <= 1'b0;
            act_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            if (ctl.load)
            begin
                act_reg <= 1'b0;
                unique case (ctl.start_sel)
                    START_LAST: rd_idx_reg <= (count_reg == '0) ? count_reg
                                                                 : count_reg - CNT_W'(1);
                    START_END:  rd_idx_reg <= count_reg;
                    default:    rd_idx_reg <= '0;
                endcase
            end
            else
            begin
                act_reg    <= act_next;
                rd_idx_reg <= rd_idx_next;
            end
            if (ctl.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pend_idx_reg <= pend_idx_next;
        hold_reg     <= hold_next;
        if (ctl.load)
        begin
            value_reg       <= data_value;
            mode_insert_reg <= ctl.mode_insert;
            match_reg       <= ctl.match_kind;
            skip_reg        <= ctl.skip;
            reject_reg      <= ctl.reject;
        end
        if (ctl.finish)
        begin
            found_reg        <= !mode_insert_reg && act_reg;
            result_value_reg <= (!mode_insert_reg && act_reg) ? $signed(hold_reg) : '0;
            full_error_reg   <= reject_reg;
            entry_count_reg  <= COUNT_OUT_W'(count_next);
        end
    end

    always_comb
    begin
        st.full       = (count_reg == CAP_CNT);
        st.scan_done  = (rd_idx_reg >= count_reg);
        st.pend_valid = pend_valid_reg;
        st.out_free   = !out_valid_reg || !out_stall;
    end

    assign out_valid    = out_valid_reg;
    assign result_value = result_value_reg;
    assign found        = found_reg;
    assign full_error   = full_error_reg;
    assign entry_count  = entry_count_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_CNT)
        else $error("entry count above capacity");

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && mode_insert_reg) |-> (count_reg < CAP_CNT))
        else $error("insert write while store full");

    a_remove_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.finish && !skip_reg && !mode_insert_reg && act_reg)
        |=> (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("removal did not drop the count");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.finish && !skip_reg && mode_insert_reg)
        |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("insert did not raise the count");

endmodule

// ----- hdl/sorted_insert_deque_unit.sv -----
// Channel  Handshake            Payload
// -------  -------------------  ----------------------------------------------
// in       in_valid / in_stall  cmd, data_value
// out      out_valid/ out_stall result_value, found, full_error, entry_count
//
// One command beat in, one result beat out. A command that walks a non-empty store
// is accepted, reads each entry from the RAM in turn, waits while the last read returns
// and its write lands, then finishes. Pop back reads one entry; push back and any walk
// of an empty store read none; rejected pushes and unused codes go straight to finish.
// The scan issues one RAM read per cycle.
// Reset clears the count and the control; entries need no clearing pass.
// A stalled result waits in the output register; the next command is taken
// meanwhile and holds in its finish step until that register frees.
module sorted_insert_deque_unit #(
    parameter int CAPACITY = sidq_pkg::SIDQ_CAPACITY
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [2:0]                          cmd,
    input  logic signed [sidq_pkg::DATA_W-1:0]  data_value,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [sidq_pkg::DATA_W-1:0]  result_value,
    output logic                                found,
    output logic                                full_error,
    output logic [sidq_pkg::COUNT_OUT_W-1:0]    entry_count
);
    import sidq_pkg::*;

    ctrl_cmd_t  ctl;
    dp_status_t st;

    sidq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cmd      (cmd),
        .st       (st),
        .ctl      (ctl)
    );

    sidq_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .st           (st),
        .data_value   (data_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_value (result_value),
        .found        (found),
        .full_error   (full_error),
        .entry_count  (entry_count)
    );

endmodule
